// File: rtl/core/ovn_pkg.sv
// ovn_pkg: shared types, constants and register codes of the octave value noise block
// no dependencies; used by every module under rtl/core
package ovn_pkg;

    localparam int MAX_OCTAVES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // operand width of the shared signed multiplier
    localparam int MW     = 36;
    // divisor width of the shared divider
    localparam int DSW    = 16;
    localparam int CFG_AW = 5;
    localparam int SUM_W  = 40;

    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_M1    = 32'd15731;
    localparam logic [31:0] HASH_A1    = 32'd789221;
    localparam logic [31:0] HASH_M2    = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] GAIN_CAP   = 32'hffff_ffff;
    localparam logic signed [MW-1:0] ONE_Q30 = MW'(36'sh0_4000_0000);
    localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7f_ffff_ffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

    typedef enum logic [2:0] {
        REG_SEED      = 3'd0,
        REG_PERIOD    = 3'd1,
        REG_AMPLITUDE = 3'd2,
        REG_OCTAVES   = 3'd3,
        REG_PERSIST   = 3'd4,
        REG_INTERP    = 3'd5
    } t_reg;

    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] period;
        logic [15:0] amplitude;
        logic [4:0]  octave_count;
        logic [15:0] persistence;
        logic        interp_mode;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_SS, S_HS, S_HS2, S_OCT, S_DIV,
        S_LA, S_LB, S_LC, S_LD,
        S_B1, S_L2, S_C2, S_C3, S_C4, S_C5, S_C6,
        S_T, S_ACC, S_GDIV, S_DONE
    } t_state;

endpackage

// File: rtl/core/octave_value_noise_1d.sv
// octave_value_noise_1d: fractal 1-D value noise, top level and sequencer
// depends on ovn_pkg, ovn_cfg, ovn_mul and ovn_div
//
// usage: settings are written over the APB port (seed, period, amplitude,
// octave count, persistence, interpolation mode at byte addresses 0..20)
// while the block is idle. a coordinate transaction is taken on i_valid
// when o_stall is low; o_stall then stays high until the finished sum moves
// into the output register. each octave runs one long division of
// coord*2^i*2^30 by period, then the hash states S_LA to S_LD per lattice
// point (2 points linear, 4 cubic) on the shared multiplier, the blend
// states, scaling and accumulation, a gain division on the same divider
// (skipped when persistence is zero) and one octave check.
// an item adds seed-hashing setup states (S_SS, S_HS, S_HS2) after its
// transaction and a wrap-up through the last octave check and the done state.
// the result sits in an output register: o_valid holds with o_noise_sum
// stable while i_stall is high, and a new coordinate is taken meanwhile.
// a finished sum waits in the done state until the output register frees.
// reset returns the settings to their defaults and drops o_valid.
module octave_value_noise_1d #(
    parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = ovn_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ovn_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [31:0]         i_coord,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [ovn_pkg::SUM_W-1:0] o_noise_sum
);
    localparam int MW   = ovn_pkg::MW;
    localparam int NUMW = 32 + MAX_OCTAVES;
    localparam int DVW  = NUMW + 30;
    localparam int CW   = $clog2(MAX_OCTAVES + 1);
    localparam int TSH  = 44 - FRAC_BITS;

    ovn_pkg::t_cfg   cfg;
    ovn_pkg::t_state r_state, n_state;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic                   div_start, div_done;
    logic [DVW-1:0]         div_dividend, div_quo;
    logic [ovn_pkg::DSW-1:0] div_divisor;

    logic                   r_neg, n_neg;
    logic [31:0]            r_mag, n_mag;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_i, n_i;
    logic [31:0]            r_g, n_g;
    logic signed [ovn_pkg::SUM_W-1:0] r_acc, n_acc;
    logic [31:0]            r_hs, n_hs;
    logic [31:0]            r_idx, n_idx;
    logic signed [MW-1:0]   r_f, n_f;
    logic signed [MW-1:0]   r_f2, n_f2;
    logic signed [MW-1:0]   r_y, n_y;
    logic [31:0]            r_a, n_a;
    logic [1:0]             r_k, n_k;
    logic signed [MW-1:0]   r_v [4];
    logic signed [MW-1:0]   n_v [4];
    logic                   r_ovalid, n_ovalid;
    logic signed [ovn_pkg::SUM_W-1:0] r_osum, n_osum;

    logic [31:0]            pt, pt_a, inner, h;
    logic signed [2*MW-1:0] prod_sh;
    logic signed [MW-1:0]   pq30;
    logic signed [MW-1:0]   cp, cq;
    logic signed [2*MW-1:0] term;
    logic signed [2*MW:0]   sum;
    logic [5:0]             oc_cap;
    logic [NUMW-1:0]        num;
    logic [31:0]            quo_q;

    ovn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ovn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ovn_div #(.DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // lattice point of the current neighbour, cubic starts one below the index
    assign pt      = r_idx + {30'd0, r_k} - {31'd0, cfg.interp_mode};
    assign pt_a    = (pt << ovn_pkg::HASH_SHIFT) ^ pt;
    assign inner   = prod[31:0] + ovn_pkg::HASH_A1;
    assign h       = (prod[31:0] + r_hs) & ovn_pkg::HASH_MASK;
    assign prod_sh = prod >>> 30;
    assign pq30    = prod_sh[MW-1:0];
    assign cp      = (r_v[3] - r_v[2]) - (r_v[0] - r_v[1]);
    assign cq      = (r_v[0] - r_v[1]) - cp;
    assign term    = prod >>> TSH;
    assign sum     = {{(2*MW+1-ovn_pkg::SUM_W){r_acc[ovn_pkg::SUM_W-1]}}, r_acc}
                     + {term[2*MW-1], term};
    assign oc_cap  = ({1'b0, cfg.octave_count} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                     : {1'b0, cfg.octave_count};
    assign num     = NUMW'(r_mag) << r_i;
    assign quo_q   = div_quo[61:30];

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_g      = r_g;
        n_acc    = r_acc;
        n_hs     = r_hs;
        n_idx    = r_idx;
        n_f      = r_f;
        n_f2     = r_f2;
        n_y      = r_y;
        n_a      = r_a;
        n_k      = r_k;
        n_v      = r_v;
        n_osum   = r_osum;
        n_ovalid = r_ovalid && i_stall;
        mul_a    = '0;
        mul_b    = '0;
        div_start    = 1'b0;
        div_dividend = {num, 30'd0};
        div_divisor  = cfg.period;

        unique case (r_state)
            ovn_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_coord[31];
                    n_mag   = i_coord[31] ? (~i_coord + 32'd1) : i_coord;
                    n_cnt   = (cfg.period == '0) ? '0 : CW'(oc_cap);
                    n_g     = {cfg.amplitude, 16'd0};
                    n_acc   = '0;
                    n_i     = '0;
                    n_state = ovn_pkg::S_SS;
                end
            end
            ovn_pkg::S_SS: begin
                mul_a   = MW'(cfg.seed);
                mul_b   = MW'(cfg.seed);
                n_state = ovn_pkg::S_HS;
            end
            ovn_pkg::S_HS: begin
                mul_a   = MW'(prod[31:0]);
                mul_b   = MW'(ovn_pkg::HASH_M2);
                n_state = ovn_pkg::S_HS2;
            end
            ovn_pkg::S_HS2: begin
                n_hs    = prod[31:0];
                n_state = ovn_pkg::S_OCT;
            end
            ovn_pkg::S_OCT: begin
                if ((r_i >= r_cnt) || (r_g == '0)) begin
                    n_state = ovn_pkg::S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ovn_pkg::S_DIV;
                end
            end
            ovn_pkg::S_DIV: begin
                if (div_done) begin
                    n_idx   = r_neg ? (32'd0 - quo_q) : quo_q;
                    n_f     = r_neg ? -MW'(div_quo[29:0]) : MW'(div_quo[29:0]);
                    n_k     = '0;
                    n_state = ovn_pkg::S_LA;
                end
            end
            ovn_pkg::S_LA: begin
                n_a     = pt_a;
                mul_a   = MW'(pt_a);
                mul_b   = MW'(pt_a);
                n_state = ovn_pkg::S_LB;
            end
            ovn_pkg::S_LB: begin
                mul_a   = MW'(prod[31:0]);
                mul_b   = MW'(ovn_pkg::HASH_M1);
                n_state = ovn_pkg::S_LC;
            end
            ovn_pkg::S_LC: begin
                mul_a   = MW'(r_a);
                mul_b   = MW'(inner);
                n_state = ovn_pkg::S_LD;
            end
            ovn_pkg::S_LD: begin
                n_v[r_k] = ovn_pkg::ONE_Q30 - MW'(h);
                if (r_k == {cfg.interp_mode, 1'b1}) begin
                    n_state = ovn_pkg::S_B1;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ovn_pkg::S_LA;
                end
            end
            ovn_pkg::S_B1: begin
                if (cfg.interp_mode) begin
                    mul_a   = r_f;
                    mul_b   = r_f;
                    n_state = ovn_pkg::S_C2;
                end else begin
                    mul_a   = r_v[1] - r_v[0];
                    mul_b   = r_f;
                    n_state = ovn_pkg::S_L2;
                end
            end
            ovn_pkg::S_L2: begin
                n_y     = r_v[0] + pq30;
                n_state = ovn_pkg::S_T;
            end
            ovn_pkg::S_C2: begin
                // f squared, then times f for the cube
                n_f2    = pq30;
                mul_a   = pq30;
                mul_b   = r_f;
                n_state = ovn_pkg::S_C3;
            end
            ovn_pkg::S_C3: begin
                mul_a   = cp;
                mul_b   = pq30;
                n_state = ovn_pkg::S_C4;
            end
            ovn_pkg::S_C4: begin
                n_y     = pq30;
                mul_a   = cq;
                mul_b   = r_f2;
                n_state = ovn_pkg::S_C5;
            end
            ovn_pkg::S_C5: begin
                n_y     = r_y + pq30;
                mul_a   = r_v[2] - r_v[0];
                mul_b   = r_f;
                n_state = ovn_pkg::S_C6;
            end
            ovn_pkg::S_C6: begin
                n_y     = r_y + pq30 + r_v[1];
                n_state = ovn_pkg::S_T;
            end
            ovn_pkg::S_T: begin
                mul_a   = r_y >>> 10;
                mul_b   = MW'(r_g);
                n_state = ovn_pkg::S_ACC;
            end
            ovn_pkg::S_ACC: begin
                priority if (sum > (2*MW+1)'(ovn_pkg::SUM_MAX)) begin
                    n_acc = ovn_pkg::SUM_MAX;
                end else if (sum < (2*MW+1)'(ovn_pkg::SUM_MIN)) begin
                    n_acc = ovn_pkg::SUM_MIN;
                end else begin
                    n_acc = sum[ovn_pkg::SUM_W-1:0];
                end
                if (cfg.persistence == '0) begin
                    n_g     = ovn_pkg::GAIN_CAP;
                    n_i     = r_i + 1'b1;
                    n_state = ovn_pkg::S_OCT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DVW'({r_g, 8'd0});
                    div_divisor  = cfg.persistence;
                    n_state      = ovn_pkg::S_GDIV;
                end
            end
            ovn_pkg::S_GDIV: begin
                if (div_done) begin
                    n_g     = (div_quo > DVW'(ovn_pkg::GAIN_CAP)) ? ovn_pkg::GAIN_CAP
                              : div_quo[31:0];
                    n_i     = r_i + 1'b1;
                    n_state = ovn_pkg::S_OCT;
                end
            end
            ovn_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_osum   = r_acc;
                    n_ovalid = 1'b1;
                    n_state  = ovn_pkg::S_IDLE;
                end
            end
            default: n_state = ovn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ovn_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_g    <= n_g;
        r_acc  <= n_acc;
        r_hs   <= n_hs;
        r_idx  <= n_idx;
        r_f    <= n_f;
        r_f2   <= n_f2;
        r_y    <= n_y;
        r_a    <= n_a;
        r_k    <= n_k;
        r_v    <= n_v;
        r_osum <= n_osum;
    end

    assign o_stall     = r_state != ovn_pkg::S_IDLE;
    assign o_valid     = r_ovalid;
    assign o_noise_sum = r_osum;
endmodule

// File: rtl/core/ovn_mul.sv
// ovn_mul: shared signed multiplier with registered product
// depends on ovn_pkg for the operand width
module ovn_mul (
    input  logic                          i_clk,
    input  logic signed [ovn_pkg::MW-1:0] i_a,
    input  logic signed [ovn_pkg::MW-1:0] i_b,
    output logic signed [2*ovn_pkg::MW-1:0] o_prod
);
    logic signed [2*ovn_pkg::MW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// File: rtl/core/ovn_div.sv
// ovn_div: restoring divider, one quotient bit per cycle
// depends on ovn_pkg for the divisor width
module ovn_div #(
    parameter int DVW = 78
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DVW-1:0]           i_dividend,
    input  logic [ovn_pkg::DSW-1:0]  i_divisor,
    output logic                     o_done,
    output logic [DVW-1:0]           o_quo
);
    localparam int CW = $clog2(DVW);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [ovn_pkg::DSW-1:0] r_dsr;
    logic [ovn_pkg::DSW-1:0] r_rem;
    logic [DVW-1:0]          r_quo;
    logic [ovn_pkg::DSW:0]   trial;
    logic                    fits;

    assign trial = {r_rem, r_quo[DVW-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? ovn_pkg::DSW'(trial - {1'b0, r_dsr}) : trial[ovn_pkg::DSW-1:0];
            r_quo <= {r_quo[DVW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: rtl/core/ovn_cfg.sv
// ovn_cfg: APB-style register file for the noise settings
// depends on ovn_pkg for register codes and the settings struct
module ovn_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ovn_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ovn_pkg::t_cfg              o_cfg
);
    ovn_pkg::t_cfg r_cfg;
    ovn_pkg::t_reg sel;

    assign sel    = ovn_pkg::t_reg'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed         <= '0;
            r_cfg.period       <= 16'd1;
            r_cfg.amplitude    <= 16'd256;
            r_cfg.octave_count <= 5'd1;
            r_cfg.persistence  <= 16'd256;
            r_cfg.interp_mode  <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                ovn_pkg::REG_SEED:      r_cfg.seed         <= pwdata;
                ovn_pkg::REG_PERIOD:    r_cfg.period       <= pwdata[15:0];
                ovn_pkg::REG_AMPLITUDE: r_cfg.amplitude    <= pwdata[15:0];
                ovn_pkg::REG_OCTAVES:   r_cfg.octave_count <= pwdata[4:0];
                ovn_pkg::REG_PERSIST:   r_cfg.persistence  <= pwdata[15:0];
                ovn_pkg::REG_INTERP:    r_cfg.interp_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            ovn_pkg::REG_SEED:      prdata = r_cfg.seed;
            ovn_pkg::REG_PERIOD:    prdata = {16'd0, r_cfg.period};
            ovn_pkg::REG_AMPLITUDE: prdata = {16'd0, r_cfg.amplitude};
            ovn_pkg::REG_OCTAVES:   prdata = {27'd0, r_cfg.octave_count};
            ovn_pkg::REG_PERSIST:   prdata = {16'd0, r_cfg.persistence};
            ovn_pkg::REG_INTERP:    prdata = {31'd0, r_cfg.interp_mode};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// File: rtl/core/ovn_checker.sv
// ovn_checker: port-level assertions for octave_value_noise_1d
// depends on ovn_pkg; attached to the top level by the bind below
module ovn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [ovn_pkg::SUM_W-1:0]       o_noise_sum
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_sum))
        else $error("stalled result changed");

    // an accepted coordinate makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after input transaction");

    // a new result only comes out of a busy phase
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work");

    // reset empties the output and frees the input
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset state wrong");
endmodule

bind octave_value_noise_1d ovn_checker u_ovn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_noise_sum (o_noise_sum)
);
